// ----- rtl/fsnds_pkg.sv -----
`default_nettype none
package fsnds_pkg;

  localparam int unsigned ENTRIES  = 224;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // compare width for the 8-bit write index against a cell index
  localparam int unsigned SEL_W    = (IDX_W > 8) ? IDX_W : 8;
  localparam int unsigned NAME_LEN = 11;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [3:0] ATTR_POS  = 4'd11;
  localparam logic [7:0] SKIP_MASK = 8'h18;  // volume label | directory
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] DOT       = 8'h2E;

  typedef logic [NAME_LEN-1:0][7:0] name_t;

  // directory byte write, broadcast to all cells
  typedef struct packed {
    logic       en;
    logic [3:0] pos;
    logic [7:0] val;
  } wr_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage
`default_nettype wire

// ----- rtl/fsnds_cell.sv -----
`default_nettype none
module fsnds_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fsnds_pkg::wr_t             wr_i,
  input  wire logic                       sel_i,
  input  wire logic [fsnds_pkg::IDX_W-1:0] my_idx_i,
  input  wire fsnds_pkg::name_t           query_i,
  input  wire fsnds_pkg::tok_t            tok_i,
  output      fsnds_pkg::tok_t            tok_o
);

  fsnds_pkg::name_t name_q;
  logic [7:0]       attr_q;
  fsnds_pkg::tok_t  tok_q, tok_d;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (name_q[0] == 8'h00) begin
        tok_d.done = 1'b1;  // end of table
      end else if (((attr_q & fsnds_pkg::SKIP_MASK) == 8'h00) && (name_q == query_i)) begin
        tok_d.done = 1'b1;
        tok_d.hit  = 1'b1;
        tok_d.idx  = my_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= '0;
      attr_q <= '0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.en && sel_i) begin
        if (wr_i.pos < fsnds_pkg::ATTR_POS) begin
          name_q[wr_i.pos] <= wr_i.val;
        end else if (wr_i.pos == fsnds_pkg::ATTR_POS) begin
          attr_q <= wr_i.val;
        end
      end
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ----- rtl/fsnds_query.sv -----
`default_nettype none
module fsnds_query (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             append_i,
  input  wire logic [7:0]       char_i,
  input  wire logic             clear_i,
  output      fsnds_pkg::name_t name_o
);

  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7A;
  localparam logic [7:0] UP_DELTA = 8'h20;
  localparam logic [3:0] NAME_END = 4'(fsnds_pkg::NAME_LEN);
  localparam logic [3:0] EXT_POS  = 4'd8;

  fsnds_pkg::name_t name_q;
  logic [3:0]       pos_q;
  logic [7:0]       upc;

  assign upc = ((char_i >= LOWER_A) && (char_i <= LOWER_Z)) ? (char_i - UP_DELTA) : char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= {fsnds_pkg::NAME_LEN{fsnds_pkg::SPACE}};
      pos_q  <= '0;
    end else if (clear_i) begin
      name_q <= {fsnds_pkg::NAME_LEN{fsnds_pkg::SPACE}};
      pos_q  <= '0;
    end else if (append_i && (char_i != 8'h00) && (pos_q < NAME_END)) begin
      if ((char_i == fsnds_pkg::DOT) && (pos_q <= EXT_POS)) begin
        pos_q <= EXT_POS;
      end else begin
        name_q[pos_q] <= upc;
        pos_q         <= pos_q + 4'd1;
      end
    end
  end

  assign name_o = name_q;

endmodule
`default_nettype wire

// ----- rtl/fat_short_name_directory_search.sv -----
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | op, entry_index, byte_position,
//         |           |                            | byte_value, query_char
// out     | output    | out_valid_o / out_ready_i  | found, match_index
//
// Writes and query characters are taken back to back while no search is in the row.
// A search walks a token down the row of ENTRIES entry cells, one cell per
// cycle; out_valid_o is registered from the token leaving the last cell, and
// no item is taken while the token is in the row.
// A search item is held off while the previous result still waits at the output;
// writes and characters are still taken then.
// Reset clears every entry, the query (eleven spaces) and all handshake state.
`default_nettype none
module fat_short_name_directory_search (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] entry_index_i,
  input  wire logic [3:0] byte_position_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [7:0] query_char_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       found_o,
  output      logic [7:0] match_index_o
);

  localparam int unsigned N = fsnds_pkg::ENTRIES;

  logic                         accept;
  logic                         busy_q;
  logic                         out_valid_q;
  logic                         found_q;
  logic [7:0]                   match_q;
  fsnds_pkg::wr_t               wr;
  fsnds_pkg::name_t             query;
  fsnds_pkg::tok_t              tok [N+1];
  logic [fsnds_pkg::SEL_W-1:0]  tail_idx;

  // ready: idle row, and a search only when the output slot is free
  assign in_ready_o = !busy_q && !((op_i == fsnds_pkg::OP_SEARCH) && out_valid_q);
  assign accept     = in_valid_i && in_ready_o;

  assign wr.en  = accept && (op_i == fsnds_pkg::OP_WRITE);
  assign wr.pos = byte_position_i;
  assign wr.val = byte_value_i;

  // fresh token enters cell 0 on a search
  assign tok[0].vld  = accept && (op_i == fsnds_pkg::OP_SEARCH);
  assign tok[0].done = 1'b0;
  assign tok[0].hit  = 1'b0;
  assign tok[0].idx  = '0;

  fsnds_query u_query (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .append_i (accept && (op_i == fsnds_pkg::OP_APPEND)),
    .char_i   (query_char_i),
    .clear_i  (tok[N].vld),
    .name_o   (query)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic sel;
    // indexes at or above ENTRIES match no cell and are dropped
    assign sel = (fsnds_pkg::SEL_W'(entry_index_i) == fsnds_pkg::SEL_W'(i));

    fsnds_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .sel_i    (sel),
      .my_idx_i (fsnds_pkg::IDX_W'(i)),
      .query_i  (query),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  // token leaves the row; idx is zero unless it hit
  assign tail_idx = fsnds_pkg::SEL_W'(tok[N].idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      match_q     <= '0;
    end else begin
      if (tok[0].vld) begin
        busy_q <= 1'b1;
      end else if (tok[N].vld) begin
        busy_q <= 1'b0;
      end
      if (tok[N].vld) begin
        out_valid_q <= 1'b1;
        found_q     <= tok[N].hit;
        match_q     <= tail_idx[7:0];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;

endmodule
`default_nettype wire

// ----- rtl/fsnds_checker.sv -----
`default_nettype none
module fsnds_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] op_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       found_o,
  input wire logic [7:0] match_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(match_index_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_index_o == 8'd0)
    else $error("miss with nonzero index");

  a_search_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (op_i == fsnds_pkg::OP_SEARCH) && out_valid_o |-> !in_ready_o)
    else $error("search taken while result pending");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while input side was idle");

endmodule

bind fat_short_name_directory_search fsnds_checker u_fsnds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .found_o       (found_o),
  .match_index_o (match_index_o)
);
`default_nettype wire

// ----- tb/fat_short_name_directory_search_test.sv -----
module fat_short_name_directory_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  // op 3 has no name in the package; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TARGET_ITEMS = 1400;
  // a search holds the input while its token is in the row; add room for output stalls
  localparam int unsigned WATCHDOG_CYCLES = 20 * fsnds_pkg::ENTRIES;

  typedef struct packed {
    logic       found;
    logic [7:0] idx;
  } lookup_t;

  // one directed item; a row with typed set carries its lookup result inline
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [3:0] pos;
    logic [7:0] val;
    logic [7:0] ch;
    logic       typed;
    logic       found;
    logic [7:0] hit_idx;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 28;

  // Entry 0 is built as "A       B  " (A.B), looked up with lower case and a
  // zero character thrown in, then turned into a directory so the same query
  // misses, and finally cut off by a zero first byte (end of table).
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{fsnds_pkg::OP_SEARCH, 8'd0, 4'd0, 8'h00, 8'h00, 1'b1, 1'b0, 8'd0},  // empty table
    '{OP_UNUSED, 8'hFF, 4'hF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0},  // unused opcode
    '{fsnds_pkg::OP_WRITE, 8'hFF, 4'd0, "A", 8'h00, 1'b0, 1'b0, 8'd0},  // entry out of range
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'hF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'd0},  // position out of range
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd0, "A", 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd1, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd2, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd3, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd4, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd5, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd6, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd7, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd8, "B", 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd9, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd10, fsnds_pkg::SPACE, 8'h00, 1'b0, 1'b0, 8'd0},
    // archive bit only
    '{fsnds_pkg::OP_WRITE, 8'd0, fsnds_pkg::ATTR_POS, 8'h20, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, "a", 1'b0, 1'b0, 8'd0},  // folded to upper case
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},  // zero char, no effect
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, fsnds_pkg::DOT, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, "b", 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_SEARCH, 8'd0, 4'd0, 8'h00, 8'h00, 1'b1, 1'b1, 8'd0},  // hit on entry 0
    // now a directory
    '{fsnds_pkg::OP_WRITE, 8'd0, fsnds_pkg::ATTR_POS, 8'h10, 8'h00, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, "A", 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, fsnds_pkg::DOT, 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_APPEND, 8'd0, 4'd0, 8'h00, "B", 1'b0, 1'b0, 8'd0},
    '{fsnds_pkg::OP_SEARCH, 8'd0, 4'd0, 8'h00, 8'h00, 1'b1, 1'b0, 8'd0},  // directory skipped
    '{fsnds_pkg::OP_WRITE, 8'd0, 4'd0, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},  // end of table at 0
    '{fsnds_pkg::OP_SEARCH, 8'd0, 4'd0, 8'h00, 8'h00, 1'b1, 1'b0, 8'd0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] op_i = fsnds_pkg::OP_WRITE;
  logic [7:0] entry_index_i = 8'd0;
  logic [3:0] byte_position_i = 4'd0;
  logic [7:0] byte_value_i = 8'd0;
  logic [7:0] query_char_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       found_o;
  logic [7:0] match_index_o;

  fat_short_name_directory_search i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .byte_position_i(byte_position_i),
    .byte_value_i   (byte_value_i),
    .query_char_i   (query_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_index_o  (match_index_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the directory table and the query being built.
  // ---------------------------------------------------------------------------
  fsnds_pkg::name_t dir_names [fsnds_pkg::ENTRIES];
  logic [7:0]       dir_attrs [fsnds_pkg::ENTRIES];
  fsnds_pkg::name_t query_buf;
  int unsigned      query_fill;

  lookup_t lookups_due [$];   // lookup results still to come out, oldest first

  // Items that travel with the payload: a typed-in result for directed rows.
  logic    row_typed = 1'b0;
  lookup_t typed_res = '0;

  int unsigned items_taken = 0;
  int unsigned items_counted = 0;   // writes in range, nonzero query characters and searches
  int unsigned lookups_checked = 0;
  int unsigned hits_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Long run of items with neither side idling.
  logic steady = 1'b0;

  // Test-side record of the names written, used to aim queries and to pick entries to fill or cut.
  fsnds_pkg::name_t plan_names [fsnds_pkg::ENTRIES];

  function automatic void apply_item(input logic [1:0] op, input logic [7:0] idx,
                                     input logic [3:0] pos, input logic [7:0] val,
                                     input logic [7:0] ch, output logic has_res,
                                     output lookup_t res);
    has_res = 1'b0;
    res     = '0;
    case (op)
      fsnds_pkg::OP_WRITE: begin
        if (idx < fsnds_pkg::ENTRIES) begin
          if (pos < fsnds_pkg::NAME_LEN) dir_names[idx][pos] = val;
          else if (pos == fsnds_pkg::ATTR_POS) dir_attrs[idx] = val;
        end
      end
      fsnds_pkg::OP_APPEND: begin
        // zero chars and anything past a full name are dropped;
        // a dot only jumps to the extension up to position 8
        if (ch != 8'h00 && query_fill < fsnds_pkg::NAME_LEN) begin
          if (ch == fsnds_pkg::DOT && query_fill <= 8) begin
            query_fill = 8;
          end else begin
            query_buf[query_fill] = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
            query_fill++;
          end
        end
      end
      fsnds_pkg::OP_SEARCH: begin
        has_res = 1'b1;
        for (int e = 0; e < fsnds_pkg::ENTRIES; e++) begin
          if (dir_names[e][0] == 8'h00) break;   // end of table
          if ((dir_attrs[e] & fsnds_pkg::SKIP_MASK) == 8'h00 &&
              dir_names[e] == query_buf) begin
            res.found = 1'b1;
            res.idx   = 8'(e);
            break;
          end
        end
        query_buf  = {fsnds_pkg::NAME_LEN{fsnds_pkg::SPACE}};
        query_fill = 0;
      end
      default: ;
    endcase
  endfunction

  // Input side: every accepted item goes through the predictor.
  always @(posedge clk_i) begin : take_item
    logic    has_res;
    lookup_t res;
    if (in_valid_i && in_ready_o) begin
      items_taken++;
      apply_item(op_i, entry_index_i, byte_position_i, byte_value_i, query_char_i,
                 has_res, res);
      if (has_res) lookups_due.push_back(row_typed ? typed_res : res);
    end
  end

  // Output side: compare each lookup result with the oldest one expected.
  always @(posedge clk_i) begin : check_lookup
    lookup_t want;
    if (out_valid_o && out_ready_i) begin
      if (lookups_due.size() == 0) begin
        $error("lookup result with none outstanding: found %0d, index %0d",
               found_o, match_index_o);
        mismatches++;
      end else begin
        want = lookups_due.pop_front();
        lookups_checked++;
        if (want.found) hits_checked++;
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatches++;
        end
        if (match_index_o !== want.idx) begin
          $error("match_index: expected %0d, got %0d", want.idx, match_index_o);
          mismatches++;
        end
      end
    end
  end

  // Result stalls at random, about six percent of the time, none during the steady stretch.
  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 6);

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("fat_short_name_directory_search test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                           input logic [3:0] pos, input logic [7:0] val,
                           input logic [7:0] ch, input logic typed = 1'b0,
                           input lookup_t typed_exp = '0);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    op_i            <= op;
    entry_index_i   <= idx;
    byte_position_i <= pos;
    byte_value_i    <= val;
    query_char_i    <= ch;
    row_typed       <= typed;
    typed_res       <= typed_exp;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if ((op == fsnds_pkg::OP_WRITE && idx < fsnds_pkg::ENTRIES &&
         pos <= fsnds_pkg::ATTR_POS) ||
        (op == fsnds_pkg::OP_APPEND && ch != 8'h00) || op == fsnds_pkg::OP_SEARCH)
      items_counted++;
    steady <= (items_counted >= 500 && items_counted < 800);
  endtask

  // Mostly legal 8.3 characters, now and then lower case or any nonzero byte.
  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return "A" + 8'($urandom_range(25));
    if (r < 85) return "0" + 8'($urandom_range(9));
    if (r < 90) return "_";
    if (r < 95) return "a" + 8'($urandom_range(25));
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic fsnds_pkg::name_t make_name();
    fsnds_pkg::name_t n;
    int               base_len;
    int               ext_len;
    n        = {fsnds_pkg::NAME_LEN{fsnds_pkg::SPACE}};
    base_len = $urandom_range(8, 1);
    ext_len  = $urandom_range(3, 0);
    for (int i = 0; i < base_len; i++) n[i] = pick_name_char();
    for (int i = 0; i < ext_len; i++) n[8 + i] = pick_name_char();
    return n;
  endfunction

  function automatic logic [7:0] pick_attr();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 8'h20;              // archive
    if (r < 7) return 8'h00;
    if (r == 7) return 8'h10;             // directory
    if (r == 8) return 8'h08;             // volume label
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(1) == 1) return c + 8'h20;
    return c;
  endfunction

  task automatic fill_entry(input int e, input fsnds_pkg::name_t n, input logic [7:0] attr);
    for (int p = 0; p < fsnds_pkg::NAME_LEN; p++)
      send_item(fsnds_pkg::OP_WRITE, 8'(e), 4'(p), n[p], 8'($urandom));
    send_item(fsnds_pkg::OP_WRITE, 8'(e), fsnds_pkg::ATTR_POS, attr, 8'($urandom));
    plan_names[e] = n;
  endtask

  // Type a name in as base, dot, extension, with random case and some damage:
  // a leading zero char, trailing junk (late dots, overflow), a corrupted char.
  task automatic run_query(input fsnds_pkg::name_t target);
    logic [7:0] chars [$];
    int         base_len;
    int         ext_len;
    int unsigned r;
    base_len = 8;
    while (base_len > 0 && target[base_len - 1] == fsnds_pkg::SPACE) base_len--;
    ext_len = 3;
    while (ext_len > 0 && target[7 + ext_len] == fsnds_pkg::SPACE) ext_len--;
    if ($urandom_range(9) == 0) chars.push_back(8'h00);
    for (int i = 0; i < base_len; i++) chars.push_back(mix_case(target[i]));
    if (ext_len != 0 || $urandom_range(4) == 0) chars.push_back(fsnds_pkg::DOT);
    for (int i = 0; i < ext_len; i++) chars.push_back(mix_case(target[8 + i]));
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        r = $urandom_range(2);
        chars.push_back(r == 0 ? fsnds_pkg::DOT :
                        (r == 1 ? "X" : 8'($urandom_range(255))));
      end
    end
    if ($urandom_range(9) == 0 && chars.size() != 0)
      chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255));
    foreach (chars[i])
      send_item(fsnds_pkg::OP_APPEND, 8'($urandom), 4'($urandom), 8'($urandom), chars[i]);
    send_item(fsnds_pkg::OP_SEARCH, 8'($urandom), 4'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  initial begin
    int               next_free;
    int               e;
    int unsigned      r;
    fsnds_pkg::name_t n;

    foreach (dir_names[i]) begin
      dir_names[i]  = '0;
      dir_attrs[i]  = '0;
      plan_names[i] = '0;
    end
    query_buf  = {fsnds_pkg::NAME_LEN{fsnds_pkg::SPACE}};
    query_fill = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].pos,
                directed_rows[i].val, directed_rows[i].ch, directed_rows[i].typed,
                '{found: directed_rows[i].found, idx: directed_rows[i].hit_idx});

    // Random part: the table grows from entry 0 up, queries are mostly aimed
    // at names already written, and now and then the table is cut short.
    while (items_counted < TARGET_ITEMS) begin
      next_free = fsnds_pkg::ENTRIES;
      for (int i = fsnds_pkg::ENTRIES - 1; i >= 0; i--)
        if (plan_names[i][0] == 8'h00) next_free = i;
      r = $urandom_range(99);
      if (r < 30) begin
        r = $urandom_range(99);
        if (r < 55 && next_free < fsnds_pkg::ENTRIES) e = next_free;
        else if (r < 85 && next_free > 0) e = $urandom_range(next_free - 1);
        else e = $urandom_range(fsnds_pkg::ENTRIES - 1);
        // an occasional duplicate name checks that the first one wins
        if (next_free > 0 && $urandom_range(19) == 0)
          n = plan_names[$urandom_range(next_free - 1)];
        else
          n = make_name();
        fill_entry(e, n, pick_attr());
      end else if (r < 85) begin
        if (next_free > 0 && $urandom_range(3) != 0)
          run_query(plan_names[$urandom_range(next_free - 1)]);
        else
          run_query(make_name());
      end else if (r < 91) begin
        if (next_free > 1) begin
          e = $urandom_range(next_free - 1);
          send_item(fsnds_pkg::OP_WRITE, 8'(e), 4'd0, 8'h00, 8'($urandom));
          plan_names[e][0] = 8'h00;
        end
      end else begin
        repeat ($urandom_range(3, 1))
          send_item(2'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lookups_due.size() != 0) @(posedge clk_i);
    // a stray result would surface within one full scan
    repeat (fsnds_pkg::ENTRIES + 8) @(posedge clk_i);

    $display("%0d items taken, %0d lookups checked (%0d hits, %0d misses)",
             items_taken, lookups_checked, hits_checked, lookups_checked - hits_checked);
    if (mismatches == 0)
      $display("fat_short_name_directory_search test passed");
    else
      $display("fat_short_name_directory_search test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fsnds_pkg.sv
rtl/fsnds_cell.sv
rtl/fsnds_query.sv
rtl/fat_short_name_directory_search.sv
rtl/fsnds_checker.sv
tb/fat_short_name_directory_search_test.sv
